// ===== hdl/inversion_count_permutations_mod_unit_assert.svh =====
// ============================================================================
// Assertion macros for the inversion count unit
// Each check comes in a simulation form and an empty form for synthesis.
// ============================================================================
`ifndef INVERSION_COUNT_PERMUTATIONS_MOD_UNIT_ASSERT_SVH
`define INVERSION_COUNT_PERMUTATIONS_MOD_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ICPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icpm: same-cycle check failed");
// next-cycle implication
`define ICPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icpm: next-cycle check failed");
`else
`define ICPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ICPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/icpm_pkg.sv =====
// ============================================================================
// icpm_pkg
// Shared constants, types and modular arithmetic for the inversion count unit.
// ============================================================================
`default_nettype none

package icpm_pkg;

   localparam int CNT_W = 30;
   localparam int IN_W  = 10;
   localparam int CAP_W = 17;

   localparam logic [CNT_W-1:0] PRIME = 30'd1000000007;

   localparam int DEF_MAX_K = 1023;
   localparam int DEF_MAX_N = 1023;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SWEEP  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } icpm_state_type;

   // per-entry flags that travel down the update pipeline
   typedef struct packed {
      logic first;   // entry 0 of the row
      logic last;    // entry k of the row
      logic sub;     // entry index at least the row index
      logic eq;      // entry index equals the row index
      logic row1;    // first row, previous row is the implicit base row
   } icpm_tag_type;

   function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME}) begin
         s = s - {1'b0, PRIME};
      end
      return s[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sub_mod(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (a < b) begin
         d = d + {1'b0, PRIME};
      end
      return d[CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/icpm_row_bank.sv =====
// ============================================================================
// icpm_row_bank
// Ping-pong row buffers: one bank is read at two entries, the other written.
// ============================================================================
`default_nettype none

module icpm_row_bank
   import icpm_pkg::*;
#(
   parameter int MAX_K = DEF_MAX_K,
   parameter int KW    = $clog2(MAX_K + 1)
) (
   input  wire logic             clock,
   input  wire logic             rd_sel,      // 0: read bank A, write B
   input  wire logic [KW-1:0]    rd_j_addr,
   input  wire logic [KW-1:0]    rd_ji_addr,
   input  wire logic             wr_en,
   input  wire logic [KW-1:0]    wr_addr,
   input  wire logic [CNT_W-1:0] wr_data,
   output logic      [CNT_W-1:0] rd_j_data,
   output logic      [CNT_W-1:0] rd_ji_data
);

   localparam int DEPTH = MAX_K + 1;

   logic [CNT_W-1:0] mem_a [DEPTH];
   logic [CNT_W-1:0] mem_b [DEPTH];

   logic [CNT_W-1:0] rd_a_j_ff, rd_a_ji_ff, rd_b_j_ff, rd_b_ji_ff;
   logic             sel_ff;

   always_ff @(posedge clock) begin
      if (wr_en && rd_sel) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_a_j_ff  <= mem_a[rd_j_addr];
      rd_a_ji_ff <= mem_a[rd_ji_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && !rd_sel) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_b_j_ff  <= mem_b[rd_j_addr];
      rd_b_ji_ff <= mem_b[rd_ji_addr];
   end

   // align the bank choice with the registered read data
   always_ff @(posedge clock) begin
      sel_ff <= rd_sel;
   end

   assign rd_j_data  = sel_ff ? rd_b_j_ff  : rd_a_j_ff;
   assign rd_ji_data = sel_ff ? rd_b_ji_ff : rd_a_ji_ff;

endmodule

`default_nettype wire

// ===== hdl/inversion_count_permutations_mod_unit.sv =====
// ============================================================================
// inversion_count_permutations_mod_unit
// Counts permutations of 1..n with exactly k inversions, modulo 1000000007.
// ============================================================================
// A request beat carries n (req_perm_length) and k (req_inversions); n
// saturates at MAX_N and k at MAX_K. The unit builds rows 1..n of the
// Mahonian recurrence in two ping-pong row buffers held in synchronous RAM,
// updating one entry per cycle within a row, with a drain between rows,
// through a three-stage read / difference / accumulate pipeline, and
// answers with one response beat holding entry k of row n. Each row takes
// k+1 entry updates through the single write port per buffer, and the
// pipeline drains before the next row reads what this one wrote. The unit
// takes one query at a time and stalls requests while a query is running;
// a finished response waits in its own register, so a new query may start
// while the last response is still stalled. No clearing pass is needed:
// the first row reads the implicit base row instead of memory.
`default_nettype none

`include "inversion_count_permutations_mod_unit_assert.svh"

module inversion_count_permutations_mod_unit
   import icpm_pkg::*;
#(
   parameter int MAX_K = DEF_MAX_K,
   parameter int MAX_N = DEF_MAX_N
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [IN_W-1:0]  req_perm_length,
   input  wire logic [IN_W-1:0]  req_inversions,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [CNT_W-1:0] rsp_count
);

   localparam int KW = $clog2(MAX_K + 1);
   localparam int NW = (MAX_N < 2) ? 1 : $clog2(MAX_N + 1);
   localparam int WW = (KW > NW) ? KW : NW;

   // ---------------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------------
   icpm_state_type   state_ff, state_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [NW-1:0]    row_ff, row_in;
   logic [KW-1:0]    col_ff, col_in;
   logic             bank_sel_ff, bank_sel_in;
   logic [CNT_W-1:0] final_ff, final_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   // pipeline
   logic             s1_valid_ff, s1_valid_in;
   icpm_tag_type     s1_tag_ff, s1_tag_in;
   logic [KW-1:0]    s1_col_ff;
   logic             s2_valid_ff;
   icpm_tag_type     s2_tag_ff;
   logic [KW-1:0]    s2_col_ff;
   logic [CNT_W-1:0] s2_diff_ff, s2_diff_in;
   logic [CNT_W-1:0] left_ff, left_in;

   logic             req_accept;
   logic             rsp_accept;
   logic             rsp_free;
   logic [CAP_W-1:0] n_ext, k_ext, n_cap, k_cap;
   logic [WW-1:0]    col_w, row_w;
   logic [KW-1:0]    rd_ji_addr;
   logic [CNT_W-1:0] rd_j_data, rd_ji_data;
   logic [CNT_W-1:0] p_j, p_ji;
   logic [CNT_W-1:0] acc_sum;
   logic             pipe_empty;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff;

   // saturate the query at the buffer sizes
   assign n_ext = CAP_W'(req_perm_length);
   assign k_ext = CAP_W'(req_inversions);
   assign n_cap = (n_ext > CAP_W'(MAX_N)) ? CAP_W'(MAX_N) : n_ext;
   assign k_cap = (k_ext > CAP_W'(MAX_K)) ? CAP_W'(MAX_K) : k_ext;

   // address of the entry i columns to the left in the previous row
   assign col_w      = WW'(col_ff);
   assign row_w      = WW'(row_ff);
   assign rd_ji_addr = KW'(col_w - row_w);

   // ---------------------------------------------------------------------
   // sequencer: one entry issued per cycle, drain between rows
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      bank_sel_in  = bank_sel_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      s1_valid_in  = 1'b0;
      s1_tag_in    = '0;
      req_stall    = 1'b1;

      // drop the response once it is taken
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               n_in        = NW'(n_cap);
               k_in        = KW'(k_cap);
               row_in      = NW'(1);
               col_in      = '0;
               bank_sel_in = 1'b0;
               if (n_cap == '0) begin
                  // empty permutation: only k = 0 counts
                  final_in = (k_cap == '0) ? CNT_W'(1) : '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            s1_valid_in    = 1'b1;
            s1_tag_in.first = (col_ff == '0);
            s1_tag_in.last  = (col_ff == k_ff);
            s1_tag_in.sub   = (col_w >= row_w);
            s1_tag_in.eq    = (col_w == row_w);
            s1_tag_in.row1  = (row_ff == NW'(1));
            if (col_ff == k_ff) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + KW'(1);
            end
         end
         ST_DRAIN: begin
            // hold until the last write of the row has landed
            if (pipe_empty) begin
               if (row_ff == n_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  row_in      = row_ff + NW'(1);
                  col_in      = '0;
                  bank_sel_in = !bank_sel_ff;
                  state_in    = ST_SWEEP;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = final_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capture entry k of the last row as it is written
      if (s2_valid_ff && s2_tag_ff.last && (row_ff == n_ff)) begin
         final_in = acc_sum;
      end
   end

   // ---------------------------------------------------------------------
   // row buffers
   // ---------------------------------------------------------------------
   icpm_row_bank #(
      .MAX_K (MAX_K),
      .KW    (KW)
   ) u_bank (
      .clock      (clock),
      .rd_sel     (bank_sel_ff),
      .rd_j_addr  (col_ff),
      .rd_ji_addr (rd_ji_addr),
      .wr_en      (s2_valid_ff),
      .wr_addr    (s2_col_ff),
      .wr_data    (acc_sum),
      .rd_j_data  (rd_j_data),
      .rd_ji_data (rd_ji_data)
   );

   // ---------------------------------------------------------------------
   // stage 1: previous-row difference, base row substituted on row 1
   // ---------------------------------------------------------------------
   always_comb begin
      if (s1_tag_ff.row1) begin
         p_j = s1_tag_ff.first ? CNT_W'(1) : '0;
      end else begin
         p_j = rd_j_data;
      end
      priority if (!s1_tag_ff.sub) begin
         p_ji = '0;
      end else if (s1_tag_ff.row1) begin
         p_ji = s1_tag_ff.eq ? CNT_W'(1) : '0;
      end else begin
         p_ji = rd_ji_data;
      end
      s2_diff_in = sub_mod(p_j, p_ji);
   end

   // ---------------------------------------------------------------------
   // stage 2: add the entry to the left, write back
   // ---------------------------------------------------------------------
   assign acc_sum = add_mod(s2_tag_ff.first ? '0 : left_ff, s2_diff_ff);
   assign left_in = s2_valid_ff ? acc_sum : left_ff;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         bank_sel_ff  <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         bank_sel_ff  <= bank_sel_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff    <= s1_tag_in;
      s1_col_ff    <= col_ff;
      s2_tag_ff    <= s1_tag_ff;
      s2_col_ff    <= s1_col_ff;
      s2_diff_ff   <= s2_diff_in;
      left_ff      <= left_in;
      final_ff     <= final_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `ICPM_ASSERT_IMPLY(a_write_in_row, clock, reset, s2_valid_ff, (state_ff == ST_SWEEP) || (state_ff == ST_DRAIN))
   `ICPM_ASSERT_IMPLY(a_diff_reduced, clock, reset, s2_valid_ff, s2_diff_ff < PRIME)
   `ICPM_ASSERT_IMPLY(a_row_in_range, clock, reset, state_ff == ST_SWEEP, (row_ff != '0) && (row_ff <= n_ff))
   `ICPM_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, (state_ff == ST_SWEEP) || (state_ff == ST_FINISH))
   `ICPM_ASSERT_IMPLY(a_drain_to_next, clock, reset, (state_ff == ST_SWEEP) && (col_ff != k_ff), !s2_valid_ff || !s2_tag_ff.last)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ============================================================================
// tb - inversion count unit testbench
// Sends (n, k) queries to the unit and checks each count beat against a
// predictor that builds the rows of the permutation-inversion recurrence
// modulo 1000000007. Directed corners come first, then random queries with
// random gaps and stalls on both channels, plus a stretch with no idling.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import icpm_pkg::*;

   // generous ceiling: far above the slowest correct run, stalls included
   localparam longint RUN_LIMIT_NS = 64'd400_000_000;
   localparam int     MAX_GAP      = 10;
   localparam int     SHOWN_ERRORS = 10;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [IN_W-1:0]  req_perm_length;
   logic [IN_W-1:0]  req_inversions;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [CNT_W-1:0] rsp_count;

   // counts still owed by the unit, oldest first
   logic [CNT_W-1:0] pending_counts[$];
   int               error_total;
   // set for a stretch in which neither side idles
   bit               steady;
   // stall cycles still to hold the waiting count beat
   int               rsp_hold;
   int               next_hold;

   inversion_count_permutations_mod_unit #(
      .MAX_K(DEF_MAX_K),
      .MAX_N(DEF_MAX_N)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_perm_length (req_perm_length),
      .req_inversions  (req_inversions),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_count       (rsp_count)
   );

   // drive every input to a known value from time zero
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_perm_length = '0;
      req_inversions  = '0;
      rsp_stall       = 1'b0;
      error_total     = 0;
      steady          = 1'b0;
      rsp_hold        = 0;
      next_hold       = 0;
   end

   always #5 clock = ~clock;

   // Predict the number of permutations of n elements with exactly k
   // inversions. Build row i from row i-1: each entry is the one to its left
   // plus the entry above, minus the entry i places back in the row above.
   function automatic logic [CNT_W-1:0] mahonian_count(input logic [IN_W-1:0] n_in,
                                                       input logic [IN_W-1:0] k_in);
      logic [CNT_W-1:0] above[0:DEF_MAX_K];
      logic [CNT_W-1:0] row[0:DEF_MAX_K];
      logic [CNT_W:0]   acc;
      int               n;
      int               k;
      n = (n_in > DEF_MAX_N) ? DEF_MAX_N : n_in;
      k = (k_in > DEF_MAX_K) ? DEF_MAX_K : k_in;
      // base row: only the empty permutation, with zero inversions
      above[0] = CNT_W'(1);
      for (int j = 1; j <= k; j++) above[j] = '0;
      for (int i = 1; i <= n; i++) begin
         row[0] = CNT_W'(1);
         for (int j = 1; j <= k; j++) begin
            acc = {1'b0, row[j-1]} + {1'b0, above[j]};
            if (acc >= {1'b0, PRIME}) acc = acc - {1'b0, PRIME};
            if (j >= i) begin
               acc = acc + {1'b0, PRIME} - {1'b0, above[j-i]};
               if (acc >= {1'b0, PRIME}) acc = acc - {1'b0, PRIME};
            end
            row[j] = acc[CNT_W-1:0];
         end
         for (int j = 0; j <= k; j++) above[j] = row[j];
      end
      return above[k];
   endfunction

   task automatic report_error(input string what, input logic [CNT_W-1:0] expected,
                               input logic [CNT_W-1:0] actual);
      error_total++;
      if (error_total <= SHOWN_ERRORS)
         $display("%0t: %s: expected count %0d, got %0d", $realtime, what, expected,
                  actual);
   endtask

   // Send one query beat. Idle a random number of cycles first (none while
   // steady), then hold the beat until the unit takes it and queue its count.
   task automatic send_query(input logic [IN_W-1:0] n, input logic [IN_W-1:0] k);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_perm_length <= n;
      req_inversions  <= k;
      do @(posedge clock); while (req_stall);
      pending_counts.push_back(mahonian_count(n, k));
   endtask

   // Response side: hold each arriving count beat for a drawn number of
   // stall cycles, then take it and compare with the oldest queued count.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold  <= 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid) begin
         if (rsp_stall) begin
            rsp_hold  <= rsp_hold - 1;
            rsp_stall <= (rsp_hold > 1);
         end else begin
            if (pending_counts.size() == 0) begin
               report_error("count beat with no query waiting", '0, rsp_count);
            end else if (rsp_count !== pending_counts[0]) begin
               report_error("count mismatch", pending_counts[0], rsp_count);
               void'(pending_counts.pop_front());
            end else begin
               void'(pending_counts.pop_front());
            end
            next_hold = steady ? 0 : $urandom_range(0, MAX_GAP);
            rsp_hold  <= next_hold;
            rsp_stall <= (next_hold != 0);
         end
      end
   end

   // Corners: empty permutation, single element, all-ones fields, counts at
   // and just past the maximum n*(n-1)/2, and sizes big enough to wrap mod.
   task automatic test_directed_corners();
      send_query(10'd0, 10'd0);
      send_query(10'd0, 10'd1);
      send_query(10'd0, 10'd1023);
      send_query(10'd1, 10'd0);
      send_query(10'd1, 10'd1);
      send_query(10'd1, 10'd1023);
      send_query(10'd2, 10'd1);
      send_query(10'd3, 10'd3);
      send_query(10'd3, 10'd4);
      send_query(10'd5, 10'd10);
      send_query(10'd5, 10'd11);
      send_query(10'd12, 10'd66);
      send_query(10'd13, 10'd78);
      send_query(10'd20, 10'd95);
      send_query(10'd30, 10'd200);
      send_query(10'd1023, 10'd0);
      send_query(10'd1023, 10'd1);
      send_query(10'd1023, 10'd40);
      send_query(10'd40, 10'd1023);
   endtask

   // Small random queries: mostly k within reach of n, some past it, a few
   // empty permutations.
   task automatic test_random_small(input int beats);
      int n;
      int k;
      int top;
      repeat (beats) begin
         n   = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
         top = n * (n - 1) / 2 + 3;
         if (top > 80) top = 80;
         k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80) : $urandom_range(0, top);
         send_query(n[IN_W-1:0], k[IN_W-1:0]);
      end
   endtask

   // Back-to-back queries with no gaps and no stalls on either side.
   task automatic test_back_to_back(input int beats);
      steady = 1'b1;
      test_random_small(beats);
      steady = 1'b0;
   endtask

   // Few large queries: one dimension wide, the other kept small to bound
   // the run time.
   task automatic test_random_large(input int beats);
      int n;
      int k;
      for (int b = 0; b < beats; b++) begin
         if (b % 2 == 0) begin
            n = $urandom_range(512, 1023);
            k = $urandom_range(0, 60);
         end else begin
            n = $urandom_range(0, 60);
            k = $urandom_range(512, 1023);
         end
         send_query(n[IN_W-1:0], k[IN_W-1:0]);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_small(50);
      test_back_to_back(20);
      test_random_large(8);
      test_random_small(20);

      // drop valid, then wait for every queued count to come back
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_total == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog: end the run if the unit hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
